// File: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPW   = 32;
  localparam int MAG_W = 64;
  localparam int ALU_W = MAG_W + 1;
  localparam int CNT_W = $clog2(MAG_W);

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4
  } action_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_MUL0  = 11'b00000000010,
    ST_MUL1  = 11'b00000000100,
    ST_MUL2  = 11'b00000001000,
    ST_PREP  = 11'b00000010000,
    ST_GINIT = 11'b00000100000,
    ST_GEVEN = 11'b00001000000,
    ST_GLOOP = 11'b00010000000,
    ST_DIVN  = 11'b00100000000,
    ST_DIVD  = 11'b01000000000,
    ST_FIN   = 11'b10000000000
  } state_t;

  localparam logic [1:0] CMP_GT = 2'b01;
  localparam logic [1:0] CMP_LT = 2'b11;
  localparam logic [1:0] CMP_EQ = 2'b00;

endpackage

// File: src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide or compare two signed fractions, with the
// arithmetic results reduced by their greatest common divisor.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and busy stays
// high until its result is presented. A compare passes ST_MUL0 to ST_MUL2,
// an unused action only ST_MUL0. An arithmetic action passes ST_MUL0 to
// ST_MUL2, the set-up states ST_PREP and ST_GINIT, a binary gcd on the shared
// subtractor whose length depends on the operands, two restoring divisions on
// the same subtractor and ST_FIN. A reduction that meets 0/0 returns to idle
// from ST_GINIT. The result is presented for exactly one cycle with out_valid
// high and must be captured then.
module rational_arithmetic_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_action,
  input  logic signed [31:0]         in_a_num,
  input  logic signed [31:0]         in_a_den,
  input  logic signed [31:0]         in_b_num,
  input  logic signed [31:0]         in_b_den,
  output logic                       out_valid,
  output logic signed [63:0]         out_res_num,
  output logic signed [63:0]         out_res_den,
  output logic signed [1:0]          out_cmp_result,
  output logic                       out_is_zero,
  output logic                       out_invalid,
  output logic                       out_overflow
);
  import rau_pkg::*;

  state_t state_r, state_nxt;

  logic [2:0]            act_r;
  logic signed [OPW-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [OPW-1:0] mul_x, mul_y;
  logic signed [2*OPW-1:0] prod;
  logic signed [MAG_W-1:0] m0_r, m1_r, m2_r;
  logic signed [MAG_W:0]   sum;
  logic signed [MAG_W-1:0] m1_sel;
  logic                  nneg_r, dneg_r;
  logic [MAG_W-1:0]      nmag_r, dmag_r;
  logic [MAG_W-1:0]      ga_r, gb_r, g_r;
  logic [CNT_W-1:0]      k_r, cnt_r;
  logic [MAG_W-1:0]      q_r, rem_r, nq_r;
  logic [ALU_W-1:0]      alu_x, alu_y, alu_d;
  logic                  alu_ge;
  logic [MAG_W-1:0]      q_next;
  logic                  res_neg;
  logic                  ovf;

  logic                  valid_r;
  logic signed [63:0]    res_num_r, res_den_r;
  logic signed [1:0]     cmp_r;
  logic                  zero_r, inv_r, ovf_r;

  rau_sub u_sub (
    .x    (alu_x),
    .y    (alu_y),
    .diff (alu_d),
    .ge   (alu_ge)
  );

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    mul_x = an_r;
    mul_y = bd_r;
    unique case (state_r)
      ST_MUL0: begin
        mul_x = an_r;
        mul_y = (act_r == ACT_MUL) ? bn_r : bd_r;
      end
      ST_MUL1: begin
        mul_x = bn_r;
        mul_y = ad_r;
      end
      ST_MUL2: begin
        mul_x = ad_r;
        mul_y = (act_r == ACT_DIV) ? bn_r : bd_r;
      end
      default: begin
        mul_x = an_r;
        mul_y = bd_r;
      end
    endcase
  end

  assign prod   = mul_x * mul_y;
  assign m1_sel = (act_r == ACT_SUB) ? -m1_r : m1_r;
  assign sum    = (MAG_W + 1)'(m0_r) + (MAG_W + 1)'(m1_sel);

  always_comb begin
    if (state_r == ST_DIVN || state_r == ST_DIVD) begin
      alu_x = {rem_r, q_r[MAG_W-1]};
      alu_y = {1'b0, g_r};
    end else begin
      alu_x = {1'b0, ga_r};
      alu_y = {1'b0, gb_r};
    end
  end

  assign q_next = {q_r[MAG_W-2:0], alu_ge};

  always_comb begin
    res_neg = (nneg_r != dneg_r) && (nq_r != '0);
    if (q_r == '0) begin
      res_neg = nneg_r && (nq_r != '0);
    end
    ovf = q_r[MAG_W-1] ||
          (!res_neg && nq_r[MAG_W-1]) ||
          (res_neg && nq_r[MAG_W-1] && (nq_r[MAG_W-2:0] != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_nxt == ST_IDLE) && (state_r != ST_IDLE);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MUL0;
      ST_MUL0:  state_nxt = (act_r > ACT_CMP) ? ST_IDLE : ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = (act_r == ACT_CMP) ? ST_IDLE : ST_PREP;
      ST_PREP:  state_nxt = ST_GINIT;
      ST_GINIT: state_nxt = (ga_r == '0 && gb_r == '0) ? ST_IDLE : ST_GEVEN;
      ST_GEVEN: if (ga_r == '0 || ga_r[0] || gb_r[0]) state_nxt = ST_GLOOP;
      ST_GLOOP: if (ga_r == '0) state_nxt = ST_DIVN;
      ST_DIVN:  if (cnt_r == CNT_W'(MAG_W - 1)) state_nxt = ST_DIVD;
      ST_DIVD:  if (cnt_r == CNT_W'(MAG_W - 1)) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        act_r <= in_action;
        an_r  <= in_a_num[OPW-1:0];
        ad_r  <= in_a_den[OPW-1:0];
        bn_r  <= in_b_num[OPW-1:0];
        bd_r  <= in_b_den[OPW-1:0];
        res_num_r <= '0;
        res_den_r <= '0;
        cmp_r     <= CMP_EQ;
        zero_r    <= 1'b0;
        inv_r     <= 1'b0;
        ovf_r     <= 1'b0;
      end
      ST_MUL0: m0_r <= MAG_W'(prod);
      ST_MUL1: m1_r <= MAG_W'(prod);
      ST_MUL2: begin
        m2_r <= MAG_W'(prod);
        if (act_r == ACT_CMP) begin
          if (m0_r > m1_r) begin
            cmp_r <= CMP_GT;
          end else if (m0_r < m1_r) begin
            cmp_r <= CMP_LT;
          end
        end
      end
      ST_PREP: begin
        if (act_r == ACT_ADD || act_r == ACT_SUB) begin
          nneg_r <= sum[MAG_W];
          nmag_r <= sum[MAG_W] ? MAG_W'(-sum) : sum[MAG_W-1:0];
          ga_r   <= sum[MAG_W] ? MAG_W'(-sum) : sum[MAG_W-1:0];
        end else begin
          nneg_r <= m0_r[MAG_W-1];
          nmag_r <= m0_r[MAG_W-1] ? -m0_r : m0_r;
          ga_r   <= m0_r[MAG_W-1] ? -m0_r : m0_r;
        end
        dneg_r <= m2_r[MAG_W-1];
        dmag_r <= m2_r[MAG_W-1] ? -m2_r : m2_r;
        gb_r   <= m2_r[MAG_W-1] ? -m2_r : m2_r;
        k_r    <= '0;
      end
      ST_GINIT: begin
        if (ga_r == '0 && gb_r == '0) begin
          inv_r <= 1'b1;
        end else if (gb_r == '0) begin
          ga_r <= gb_r;
          gb_r <= ga_r;
        end
      end
      ST_GEVEN: begin
        if (ga_r != '0 && !ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          k_r  <= k_r + 1'b1;
        end
      end
      ST_GLOOP: begin
        if (ga_r == '0) begin
          g_r   <= gb_r << k_r;
          q_r   <= nmag_r;
          rem_r <= '0;
          cnt_r <= '0;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (alu_ge) begin
          ga_r <= alu_d[MAG_W-1:0];
        end else begin
          ga_r <= gb_r;
          gb_r <= ga_r;
        end
      end
      ST_DIVN: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          nq_r  <= q_next;
          q_r   <= dmag_r;
          rem_r <= '0;
        end else begin
          q_r   <= q_next;
          rem_r <= alu_ge ? alu_d[MAG_W-1:0] : alu_x[MAG_W-1:0];
        end
      end
      ST_DIVD: begin
        cnt_r <= cnt_r + 1'b1;
        q_r   <= q_next;
        rem_r <= alu_ge ? alu_d[MAG_W-1:0] : alu_x[MAG_W-1:0];
      end
      ST_FIN: begin
        if (ovf) begin
          ovf_r <= 1'b1;
        end else begin
          res_num_r <= res_neg ? -nq_r : nq_r;
          res_den_r <= q_r;
          zero_r    <= (nq_r == '0) && (q_r != '0);
        end
      end
      default: begin
        act_r <= act_r;
      end
    endcase
  end

  assign out_valid      = valid_r;
  assign out_res_num    = res_num_r;
  assign out_res_den    = res_den_r;
  assign out_cmp_result = cmp_r;
  assign out_is_zero    = zero_r;
  assign out_invalid    = inv_r;
  assign out_overflow   = ovf_r;

endmodule

// File: src/rau_sub.sv
// ----------------------------------------------------------------------------
// rau_sub
// Shared subtractor used by the gcd loop and the restoring divider.
// ----------------------------------------------------------------------------
module rau_sub (
  input  logic [rau_pkg::ALU_W-1:0] x,
  input  logic [rau_pkg::ALU_W-1:0] y,
  output logic [rau_pkg::ALU_W-1:0] diff,
  output logic                      ge
);
  import rau_pkg::*;

  logic [ALU_W:0] full;

  assign full = {1'b0, x} - {1'b0, y};
  assign diff = full[ALU_W-1:0];
  assign ge   = ~full[ALU_W];

endmodule

// File: bench/rational_arithmetic_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Self-checking bench for the rational arithmetic unit. A driver issues
// fraction transactions from a queue with random gaps, a monitor captures
// each strobed result and compares it field by field with the value that a
// built-in fraction calculator predicted when the transaction was taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } frac_op_t;

  typedef struct packed {
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic [1:0]         cmp;
    logic               zero;
    logic               inv;
    logic               ovf;
  } frac_res_t;

  typedef enum logic {RUN, DRAIN} bool_hold_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_action = '0;
  logic signed [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic signed [63:0] out_res_num, out_res_den;
  logic signed [1:0] out_cmp_result;
  logic out_is_zero, out_invalid, out_overflow;

  frac_op_t  pending_ops[$];
  frac_res_t expected_fracs[$];
  int        error_count = 0;
  int        issued = 0;
  int        checked = 0;
  int        idle_pct = 9;
  bool_hold_t hold;
  int        watchdog = 0;
  logic      done = 1'b0;

  rational_arithmetic_unit dut (.*);

  always #4 clk = ~clk;

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_frac(input logic nneg, input logic [63:0] nmag,
                                            input logic dneg, input logic [63:0] dmag);
    frac_res_t r;
    logic [63:0] g;
    logic neg;
    r = '0;
    g = gcd64(nmag, dmag);
    if (g == 0) begin
      r.inv = 1'b1;
      return r;
    end
    nmag = nmag / g;
    dmag = dmag / g;
    neg = (nneg != dneg) && nmag != 0;
    if (dmag == 0) neg = nneg && nmag != 0;
    if ((!neg && nmag[63]) || (neg && nmag > 64'h8000000000000000) || dmag[63]) begin
      r.ovf = 1'b1;
      return r;
    end
    r.num = neg ? -nmag : nmag;
    r.den = dmag;
    r.zero = (nmag == 0 && dmag != 0);
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic frac_res_t predict_frac(input frac_op_t op);
    frac_res_t r;
    logic signed [63:0] an, ad, bn, bd, p, q, s, den, num, ta, tb;
    logic signed [64:0] sum;
    r = '0;
    an = op.a_num; ad = op.a_den; bn = op.b_num; bd = op.b_den;
    case (op.action)
      ACT_ADD, ACT_SUB: begin
        if (op.action == ACT_SUB) bn = -bn;
        p = an * bd;
        q = bn * ad;
        sum = 65'(p) + 65'(q);
        den = ad * bd;
        r = reduce_frac(sum < 0, sum < 0 ? 64'(-sum) : 64'(sum), den < 0, mag64(den));
      end
      ACT_MUL, ACT_DIV: begin
        if (op.action == ACT_DIV) begin
          num = an * bd;
          den = ad * bn;
        end else begin
          num = an * bn;
          den = ad * bd;
        end
        r = reduce_frac(num < 0, mag64(num), den < 0, mag64(den));
      end
      ACT_CMP: begin
        ta = an * bd;
        tb = bn * ad;
        r.cmp = ta > tb ? CMP_GT : (ta < tb ? CMP_LT : CMP_EQ);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_fracs.push_back(predict_frac({in_action, in_a_num, in_a_den,
                                               in_b_num, in_b_den}));
        issued++;
      end
      if (hold == DRAIN && !start && expected_fracs.size() == 0) hold <= RUN;
      if ((start && !busy) || !start) begin
        if (pending_ops.size() > 0 && hold == RUN && !($urandom_range(99) < idle_pct)
            && !(issued == 500 && start)) begin
          frac_op_t op;
          op = pending_ops.pop_front();
          start <= 1'b1;
          {in_action, in_a_num, in_a_den, in_b_num, in_b_den} <= op;
        end else begin
          start <= 1'b0;
          if (issued == 500 && start) hold <= DRAIN;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      frac_res_t e;
      if (expected_fracs.size() == 0) begin
        $display("result with no transaction outstanding");
        error_count++;
      end else begin
        e = expected_fracs.pop_front();
        checked++;
        if (out_res_num !== e.num) report_mismatch("res_num", out_res_num, e.num);
        if (out_res_den !== e.den) report_mismatch("res_den", out_res_den, e.den);
        if (out_cmp_result !== e.cmp)
          report_mismatch("cmp_result", 64'(out_cmp_result), 64'(e.cmp));
        if (out_is_zero !== e.zero)
          report_mismatch("is_zero", 64'(out_is_zero), 64'(e.zero));
        if (out_invalid !== e.inv)
          report_mismatch("invalid", 64'(out_invalid), 64'(e.inv));
        if (out_overflow !== e.ovf)
          report_mismatch("overflow", 64'(out_overflow), 64'(e.ovf));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !done) begin
      if ((start && !busy) || out_valid) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(5))
      0: return $urandom_range(9) - 4;
      1: return 32'sh80000000 + $urandom_range(3);
      2: return 32'sh7fffffff - $urandom_range(3);
      3: return $signed($urandom_range(2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic [2:0] act, input logic signed [31:0] an, ad, bn, bd);
    pending_ops.push_back({act, an, ad, bn, bd});
  endtask

  initial begin
    frac_op_t op;
    hold = RUN;
    for (int k = 0; k < 8; k++)
      add_op(k[2:0], 32'sd3, 32'sd4, -32'sd5, 32'sd6);
    add_op(ACT_ADD, 0, 0, 0, 0);
    add_op(ACT_DIV, 7, 3, 0, 5);
    add_op(ACT_DIV, -7, 3, 0, 5);
    add_op(ACT_SUB, 5, 9, 5, 9);
    add_op(ACT_MUL, 32'sh80000000, 1, 32'sh80000000, 1);
    add_op(ACT_ADD, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    add_op(ACT_SUB, 32'sh80000000, 1, 32'sh7fffffff, -1);
    add_op(ACT_DIV, 32'sh80000000, -1, -1, 32'sh80000000);
    add_op(ACT_CMP, 1, -2, 1, 2);
    add_op(ACT_CMP, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    add_op(ACT_MUL, 0, -3, 4, 5);
    add_op(ACT_ADD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    for (int k = 0; k < 1030; k++) begin
      op.action = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                            : 3'($urandom_range(4));
      op.a_num = rand_field(); op.a_den = rand_field();
      op.b_num = rand_field(); op.b_den = rand_field();
      pending_ops.push_back(op);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (issued >= 350);
    idle_pct = 72;
    wait (issued >= 700);
    idle_pct = 0;
    wait (pending_ops.size() == 0 && !start);
    wait (expected_fracs.size() == 0);
    repeat (400) @(posedge clk);
    done = 1'b1;
    $display("issued %0d fraction transactions with all actions, extreme operands",
             issued);
    $display("and mixed idle patterns; %0d results checked", checked);
    if (error_count == 0 && expected_fracs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/rau_pkg.sv
src/rau_sub.sv
src/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_test.sv
